### design/gsga_pkg.sv
// Shared types, constants and the exp table function of the Gaussian splat grid accumulator.
package gsga_pkg;

  localparam int CoordW   = 32;
  localparam int SumW     = 48;
  localparam int WeightW  = 32;
  localparam int CountW   = 16;
  localparam int ReadIdxW = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int DimW     = 7;
  localparam int NormW    = 18;
  localparam int TableW   = 16;

  localparam int MaxColsDef  = 64;
  localparam int MaxRowsDef  = 64;
  localparam int ExpDepthDef = 256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_MZ  = 3'd0,
    CFG_STEP_MZ = 3'd1,
    CFG_MIN_RT  = 3'd2,
    CFG_STEP_RT = 3'd3,
    CFG_COLS    = 3'd4,
    CFG_ROWS    = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WIN_SETUP,
    S_DIV,
    S_WIN_END,
    S_CX,
    S_D,
    S_NX_START,
    S_NX_END,
    S_NY_END,
    S_SQ,
    S_K,
    S_ROM,
    S_MUL,
    S_WB
  } state_e;

  typedef struct packed {
    logic                op;
    logic [CoordW-1:0]   point_mz;
    logic [CoordW-1:0]   point_rt;
    logic [CoordW-1:0]   intensity;
    logic [CoordW-1:0]   width_mz;
    logic [CoordW-1:0]   width_rt;
    logic [ReadIdxW-1:0] read_col;
    logic [ReadIdxW-1:0] read_row;
  } item_t;

  typedef struct packed {
    logic               splat_accepted;
    logic [SumW-1:0]    cell_sum_out;
    logic [WeightW-1:0] cell_weight_out;
    logic [CountW-1:0]  cell_count_out;
  } result_t;

  // exp(-u)^8 in Q0.16 for u in Q1.31; used only on constants
  function automatic logic [TableW-1:0] exp_entry(input logic [63:0] u);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    term = 64'h8000_0000;
    sum  = 64'h8000_0000;
    for (int i = 1; i <= 16; i++) begin
      term = ((term * u) >> 31) / 64'(i);
      if ((i % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > 64'h8000_0000) begin
      sum = 64'h8000_0000;
    end
    for (int i = 0; i < 3; i++) begin
      sum = (sum * sum) >> 31;
    end
    r = (sum + 64'h4000) >> 15;
    return (r > 64'd65535) ? 16'hFFFF : r[TableW-1:0];
  endfunction

endpackage

### design/gaussian_splat_grid_accumulator_core.sv
// Gaussian splat grid accumulator: cell store, window search and per-cell weighting.
// Read item: the result is registered after the states RD1 and RD2. A rejected splat ends without writing the store.
// Accepted splat: the window divisions run first on the shared divider,
// then each cell takes two divisions of 18 quotient bits, or none beyond four sigmas.
// One item at a time; busy is high from start to the done strobe, results cannot be held off.
// After reset a clearing sweep zeroes every cell of the store while busy is high.
module gaussian_splat_grid_accumulator_core #(
  parameter int MaxCols  = gsga_pkg::MaxColsDef,
  parameter int MaxRows  = gsga_pkg::MaxRowsDef,
  parameter int ExpDepth = gsga_pkg::ExpDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  gsga_pkg::item_t               item_i,
  output logic                          busy,
  output logic                          done_o,
  output gsga_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [gsga_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gsga_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int Cells = MaxCols * MaxRows;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(MaxCols);
  localparam int RW    = $clog2(MaxRows);
  localparam int CXW   = 33 + CW;
  localparam int CYW   = 33 + RW;
  localparam int KW    = $clog2(ExpDepth);
  localparam int KPW   = 38 + KW;
  localparam int MW    = gsga_pkg::SumW + gsga_pkg::WeightW + gsga_pkg::CountW;

  // configuration
  logic [31:0] min_mz_q, step_mz_q, min_rt_q, step_rt_q;
  logic [gsga_pkg::DimW-1:0] cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mz_q  <= '0;
      step_mz_q <= 32'd65536;
      min_rt_q  <= '0;
      step_rt_q <= 32'd65536;
      cols_q    <= 7'd64;
      rows_q    <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsga_pkg::CFG_MIN_MZ:  min_mz_q  <= cfg_wdata_i;
        gsga_pkg::CFG_STEP_MZ: step_mz_q <= cfg_wdata_i;
        gsga_pkg::CFG_MIN_RT:  min_rt_q  <= cfg_wdata_i;
        gsga_pkg::CFG_STEP_RT: step_rt_q <= cfg_wdata_i;
        gsga_pkg::CFG_COLS:    cols_q    <= cfg_wdata_i[gsga_pkg::DimW-1:0];
        gsga_pkg::CFG_ROWS:    rows_q    <= cfg_wdata_i[gsga_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] stepx, stepy, ncol, nrow;
  assign stepx = (step_mz_q == '0) ? 32'd1 : step_mz_q;
  assign stepy = (step_rt_q == '0) ? 32'd1 : step_rt_q;
  assign ncol  = (cols_q == '0) ? 32'd1 :
                 (32'(cols_q) > 32'(MaxCols)) ? 32'(MaxCols) : 32'(cols_q);
  assign nrow  = (rows_q == '0) ? 32'd1 :
                 (32'(rows_q) > 32'(MaxRows)) ? 32'(MaxRows) : 32'(rows_q);

  // exp table
  logic [gsga_pkg::TableW-1:0] exp_rom [ExpDepth];
  for (genvar g = 0; g < ExpDepth; g++) begin : g_rom
    assign exp_rom[g] = gsga_pkg::exp_entry((64'(g) << 31) / ExpDepth);
  end

  // state and datapath registers
  gsga_pkg::state_e state_q, state_d, ret_q;
  gsga_pkg::item_t   item_q;
  gsga_pkg::result_t res_q;
  logic              done_q;
  logic [AW-1:0]     clr_q, addr_q;
  logic              rd_ok_q;
  logic [1:0]        ph_q;
  logic [31:0]       div_rem_q, div_v_q;
  logic [33:0]       div_bits_q, div_quo_q;
  logic [5:0]        div_cnt_q;
  logic [CW-1:0]     i0_q, i1_q, col_q;
  logic [RW-1:0]     j0_q, j1_q, row_q;
  logic [CXW-1:0]    cx_q;
  logic [CYW-1:0]    cy_q;
  logic [33:0]       dx_q, dy_q;
  logic              far_x_q, far_y_q;
  logic [gsga_pkg::NormW-1:0] ra_q, rb_q;
  logic [35:0]       sa_q, sb_q;
  logic [KW-1:0]     k_q;
  logic              kover_q;
  logic [gsga_pkg::TableW-1:0] w_q;
  logic [47:0]       prod_q;
  logic [MW-1:0]     rdata_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != gsga_pkg::S_IDLE);
  assign done_o = done_q;
  assign result_o = res_q;

  // window setup for the current phase: bit 1 picks the axis, bit 0 the high end
  logic [31:0] w_coord, w_sig, w_min, w_step, w_n;
  logic [33:0] w_two, w_low_lim, w_lo_div, w_hi_div;
  logic        sig_zero, win_fail, win_rej, last_cell;
  logic [33:0] n_ext, hi_clamp;

  always_comb begin
    w_coord   = ph_q[1] ? item_q.point_rt : item_q.point_mz;
    w_sig     = ph_q[1] ? item_q.width_rt : item_q.width_mz;
    w_min     = ph_q[1] ? min_rt_q : min_mz_q;
    w_step    = ph_q[1] ? stepy : stepx;
    w_n       = ph_q[1] ? nrow : ncol;
    w_two     = {1'b0, w_sig, 1'b0};
    w_low_lim = w_two + 34'(w_min);
    w_lo_div  = 34'(w_coord) - w_two - 34'(w_min);
    w_hi_div  = 34'(w_coord) + w_two - 34'(w_min);
    sig_zero  = (item_q.width_mz == '0) || (item_q.width_rt == '0);
    win_fail  = (ph_q == 2'd0 && sig_zero) || (!ph_q[0] && (34'(w_coord) < w_low_lim));
    n_ext     = 34'(w_n);
    win_rej   = !ph_q[0] && (div_quo_q >= n_ext);
    hi_clamp  = (div_quo_q > n_ext - 34'd1) ? n_ext - 34'd1 : div_quo_q;
    last_cell = (col_q == i1_q) && (row_q == j1_q);
  end

  // divider step
  logic [32:0] div_t;
  logic        div_ge;
  assign div_t  = {div_rem_q, div_bits_q[33]};
  assign div_ge = div_t >= {1'b0, div_v_q};

  // per-cell combinational values
  logic [CXW-1:0] dx_w, four_sx;
  logic [CYW-1:0] dy_w, four_sy;
  logic [36:0]    s_sum;
  logic [KPW-1:0] kprod;
  logic           kover_w;
  assign dx_w    = (cx_q >= CXW'(item_q.point_mz)) ? cx_q - CXW'(item_q.point_mz)
                                                   : CXW'(item_q.point_mz) - cx_q;
  assign dy_w    = (cy_q >= CYW'(item_q.point_rt)) ? cy_q - CYW'(item_q.point_rt)
                                                   : CYW'(item_q.point_rt) - cy_q;
  assign four_sx = CXW'({item_q.width_mz, 2'b00});
  assign four_sy = CYW'({item_q.width_rt, 2'b00});
  assign s_sum   = 37'(sa_q) + 37'(sb_q);
  assign kprod   = KPW'(s_sum) * KPW'(ExpDepth);
  assign kover_w = kprod[KPW-1:36] >= (KPW-36)'(ExpDepth);

  // write-back values
  logic [48:0] nsum;
  logic [32:0] nwt;
  logic [15:0] ocnt, ncnt;
  assign nsum = 49'(rdata_q[MW-1:48]) + 49'(prod_q[47:16]);
  assign nwt  = 33'(rdata_q[47:16]) + 33'(w_q);
  assign ocnt = rdata_q[15:0];
  assign ncnt = (ocnt == 16'hFFFF) ? ocnt : ocnt + 16'd1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gsga_pkg::S_CLEAR:     if (clr_q == AW'(Cells - 1)) state_d = gsga_pkg::S_IDLE;
      gsga_pkg::S_IDLE: begin
        if (accept) state_d = item_i.op ? gsga_pkg::S_RD1 : gsga_pkg::S_WIN_SETUP;
      end
      gsga_pkg::S_RD1:       state_d = gsga_pkg::S_RD2;
      gsga_pkg::S_RD2:       state_d = gsga_pkg::S_IDLE;
      gsga_pkg::S_WIN_SETUP: state_d = win_fail ? gsga_pkg::S_IDLE : gsga_pkg::S_DIV;
      gsga_pkg::S_DIV:       if (div_cnt_q == 6'd1) state_d = ret_q;
      gsga_pkg::S_WIN_END: begin
        if (win_rej) state_d = gsga_pkg::S_IDLE;
        else if (ph_q == 2'd3) state_d = gsga_pkg::S_CX;
        else state_d = gsga_pkg::S_WIN_SETUP;
      end
      gsga_pkg::S_CX:        state_d = gsga_pkg::S_D;
      gsga_pkg::S_D:         state_d = gsga_pkg::S_NX_START;
      gsga_pkg::S_NX_START:  state_d = (far_x_q || far_y_q) ? gsga_pkg::S_MUL : gsga_pkg::S_DIV;
      gsga_pkg::S_NX_END:    state_d = gsga_pkg::S_DIV;
      gsga_pkg::S_NY_END:    state_d = gsga_pkg::S_SQ;
      gsga_pkg::S_SQ:        state_d = gsga_pkg::S_K;
      gsga_pkg::S_K:         state_d = gsga_pkg::S_ROM;
      gsga_pkg::S_ROM:       state_d = gsga_pkg::S_MUL;
      gsga_pkg::S_MUL:       state_d = gsga_pkg::S_WB;
      gsga_pkg::S_WB:        state_d = last_cell ? gsga_pkg::S_IDLE : gsga_pkg::S_CX;
      default:               state_d = gsga_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsga_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      clr_q  <= '0;
    end else begin
      done_q <= ((state_q == gsga_pkg::S_RD2) ||
                 (state_q == gsga_pkg::S_WIN_SETUP && win_fail) ||
                 (state_q == gsga_pkg::S_WIN_END && win_rej) ||
                 (state_q == gsga_pkg::S_WB && last_cell));
      if (state_q == gsga_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      gsga_pkg::S_IDLE: begin
        if (accept) begin
          item_q  <= item_i;
          ph_q    <= 2'd0;
          rd_ok_q <= (32'(item_i.read_col) < MaxCols) && (32'(item_i.read_row) < MaxRows);
          addr_q  <= AW'(32'(item_i.read_row) * MaxCols + 32'(item_i.read_col));
        end
      end
      gsga_pkg::S_RD2: begin
        res_q.splat_accepted  <= 1'b0;
        res_q.cell_sum_out    <= rd_ok_q ? rdata_q[MW-1:48] : '0;
        res_q.cell_weight_out <= rd_ok_q ? rdata_q[47:16] : '0;
        res_q.cell_count_out  <= rd_ok_q ? rdata_q[15:0] : '0;
      end
      gsga_pkg::S_WIN_SETUP: begin
        if (win_fail) begin
          res_q <= '0;
        end else begin
          div_rem_q  <= '0;
          div_bits_q <= ph_q[0] ? w_hi_div : w_lo_div;
          div_quo_q  <= '0;
          div_cnt_q  <= 6'd34;
          div_v_q    <= w_step;
          ret_q      <= gsga_pkg::S_WIN_END;
        end
      end
      gsga_pkg::S_DIV: begin
        div_rem_q  <= div_ge ? 32'(div_t - {1'b0, div_v_q}) : div_t[31:0];
        div_bits_q <= {div_bits_q[32:0], 1'b0};
        div_quo_q  <= {div_quo_q[32:0], div_ge};
        div_cnt_q  <= div_cnt_q - 6'd1;
      end
      gsga_pkg::S_WIN_END: begin
        if (win_rej) begin
          res_q <= '0;
        end else begin
          case (ph_q)
            2'd0:    i0_q <= CW'(div_quo_q);
            2'd1:    i1_q <= CW'(hi_clamp);
            2'd2:    j0_q <= RW'(div_quo_q);
            default: begin
              j1_q  <= RW'(hi_clamp);
              col_q <= i0_q;
              row_q <= j0_q;
            end
          endcase
          ph_q <= ph_q + 2'd1;
        end
      end
      gsga_pkg::S_CX: begin
        cx_q <= CXW'(min_mz_q) + CXW'(col_q) * CXW'(stepx);
        cy_q <= CYW'(min_rt_q) + CYW'(row_q) * CYW'(stepy);
      end
      gsga_pkg::S_D: begin
        dx_q    <= 34'(dx_w);
        dy_q    <= 34'(dy_w);
        far_x_q <= dx_w >= four_sx;
        far_y_q <= dy_w >= four_sy;
        addr_q  <= AW'(32'(row_q) * MaxCols + 32'(col_q));
      end
      gsga_pkg::S_NX_START: begin
        if (far_x_q || far_y_q) begin
          w_q <= '0;
        end else begin
          // offset below four sigma: quotient fits in 18 bits
          div_rem_q  <= dx_q[33:2];
          div_bits_q <= {dx_q[1:0], 32'd0};
          div_quo_q  <= '0;
          div_cnt_q  <= 6'(gsga_pkg::NormW);
          div_v_q    <= item_q.width_mz;
          ret_q      <= gsga_pkg::S_NX_END;
        end
      end
      gsga_pkg::S_NX_END: begin
        ra_q       <= div_quo_q[gsga_pkg::NormW-1:0];
        div_rem_q  <= dy_q[33:2];
        div_bits_q <= {dy_q[1:0], 32'd0};
        div_quo_q  <= '0;
        div_cnt_q  <= 6'(gsga_pkg::NormW);
        div_v_q    <= item_q.width_rt;
        ret_q      <= gsga_pkg::S_NY_END;
      end
      gsga_pkg::S_NY_END: rb_q <= div_quo_q[gsga_pkg::NormW-1:0];
      gsga_pkg::S_SQ: begin
        sa_q <= 36'(ra_q) * 36'(ra_q);
        sb_q <= 36'(rb_q) * 36'(rb_q);
      end
      gsga_pkg::S_K: begin
        kover_q <= kover_w;
        k_q     <= kover_w ? '0 : KW'(kprod[KPW-1:36]);
      end
      gsga_pkg::S_ROM: w_q <= kover_q ? '0 : exp_rom[k_q];
      gsga_pkg::S_MUL: prod_q <= 48'(item_q.intensity) * 48'(w_q);
      gsga_pkg::S_WB: begin
        if (last_cell) begin
          res_q.splat_accepted  <= 1'b1;
          res_q.cell_sum_out    <= '0;
          res_q.cell_weight_out <= '0;
          res_q.cell_count_out  <= '0;
        end else if (col_q == i1_q) begin
          col_q <= i0_q;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // cell store: sum, weight, count in one word
  logic [MW-1:0] mem [Cells];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = '0;
    if (state_q == gsga_pkg::S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
    end else if (state_q == gsga_pkg::S_WB) begin
      mem_we = 1'b1;
      mem_wd = {nsum[48] ? 48'hFFFF_FFFF_FFFF : nsum[47:0],
                nwt[32] ? 32'hFFFF_FFFF : nwt[31:0],
                ncnt};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[addr_q];
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");
  a_no_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gsga_pkg::S_CLEAR) |-> !done_o)
    else $error("result during clearing sweep");
  a_cell_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gsga_pkg::S_WB) |-> (col_q >= i0_q && col_q <= i1_q &&
                                     row_q >= j0_q && row_q <= j1_q))
    else $error("cell outside splat window");
  a_splat_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.splat_accepted) |-> (result_o.cell_count_out == '0))
    else $error("splat result carries cell data");
`endif

endmodule

### tb/gsga_checker.sv
// Checker for the splat grid accumulator: mirrors the grid store, predicts results, compares.
`timescale 1ns / 1ps
module gsga_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  gsga_pkg::item_t               item_i,
  input  logic                          done_i,
  input  gsga_pkg::result_t             result_i,
  input  logic                          cfg_we_i,
  input  logic [gsga_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gsga_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);

  localparam int NCols  = 64;
  localparam int NRows  = 64;
  localparam int Depth  = 256;
  localparam logic [63:0] One31 = 64'h8000_0000;
  localparam logic [63:0] NoWeight = 64'hFFFF_FFFF;

  logic [gsga_pkg::SumW-1:0]    grid_sum    [NCols*NRows];
  logic [gsga_pkg::WeightW-1:0] grid_weight [NCols*NRows];
  logic [gsga_pkg::CountW-1:0]  grid_count  [NCols*NRows];
  logic [15:0]                  gauss_lut   [Depth];

  logic [31:0] min_mz, step_mz, min_rt, step_rt;
  logic [6:0]  cols_reg, rows_reg;

  gsga_pkg::result_t expected_results [$];

  function automatic logic [15:0] gauss_lut_entry(input int k);
    logic [63:0] u, term, acc, r;
    u = (64'(k) << 31) / Depth;
    term = One31;
    acc = One31;
    for (int i = 1; i <= 16; i++) begin
      term = ((term * u) >> 31) / 64'(i);
      if (i % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > One31) acc = One31;
    for (int i = 0; i < 3; i++) acc = (acc * acc) >> 31;
    r = (acc + 64'h4000) >> 15;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic [63:0] offset_q16(input logic [63:0] c, input logic [63:0] p,
                                             input logic [63:0] sg);
    logic [63:0] d, r;
    d = (c > p) ? c - p : p - c;
    r = (d << 16) / sg;
    return (r >= (64'd4 << 16)) ? NoWeight : r;
  endfunction

  function automatic logic [31:0] cell_gain(input logic [63:0] cx, input logic [63:0] px,
                                            input logic [63:0] sx, input logic [63:0] cy,
                                            input logic [63:0] py, input logic [63:0] sy);
    logic [63:0] ra, rb, k;
    ra = offset_q16(cx, px, sx);
    rb = offset_q16(cy, py, sy);
    if (ra == NoWeight || rb == NoWeight) return 32'd0;
    k = ((ra * ra + rb * rb) * Depth) >> 36;
    if (k >= Depth) return 32'd0;
    return 32'(gauss_lut[k]);
  endfunction

  function automatic int dim_limit(input logic [6:0] v, input int maxv);
    if (v == 0) return 1;
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  // false when the splat misses the grid on this axis
  function automatic bit span_of_axis(input logic [63:0] coord, input logic [63:0] sg,
                                      input logic [63:0] mn, input logic [63:0] st,
                                      input int n, output int lo, output int hi);
    logic [63:0] two, l, h;
    two = 2 * sg;
    lo = 0;
    hi = 0;
    if (coord < two || coord - two < mn) return 1'b0;
    l = (coord - two - mn) / st;
    if (l >= 64'(n)) return 1'b0;
    h = (coord + two - mn) / st;
    if (h > 64'(n - 1)) h = 64'(n - 1);
    lo = int'(l);
    hi = int'(h);
    return 1'b1;
  endfunction

  function automatic gsga_pkg::result_t predict_splat_or_read(input gsga_pkg::item_t it);
    gsga_pkg::result_t res;
    logic [63:0] stx, sty, cx, cy, s, wt;
    logic [31:0] w;
    int ncol, nrow, i0, i1, j0, j1, c;
    res = '0;
    stx = (step_mz == 0) ? 64'd1 : 64'(step_mz);
    sty = (step_rt == 0) ? 64'd1 : 64'(step_rt);
    ncol = dim_limit(cols_reg, NCols);
    nrow = dim_limit(rows_reg, NRows);
    if (it.op) begin
      c = int'(it.read_row) * NCols + int'(it.read_col);
      res.cell_sum_out    = grid_sum[c];
      res.cell_weight_out = grid_weight[c];
      res.cell_count_out  = grid_count[c];
      return res;
    end
    if (it.width_mz == 0 || it.width_rt == 0) return res;
    if (!span_of_axis(it.point_mz, it.width_mz, min_mz, stx, ncol, i0, i1)) return res;
    if (!span_of_axis(it.point_rt, it.width_rt, min_rt, sty, nrow, j0, j1)) return res;
    for (int j = j0; j <= j1; j++) begin
      cy = 64'(min_rt) + 64'(j) * sty;
      for (int i = i0; i <= i1; i++) begin
        cx = 64'(min_mz) + 64'(i) * stx;
        w = cell_gain(cx, it.point_mz, it.width_mz, cy, it.point_rt, it.width_rt);
        c = j * NCols + i;
        s = 64'(grid_sum[c]) + ((64'(it.intensity) * 64'(w)) >> 16);
        wt = 64'(grid_weight[c]) + 64'(w);
        grid_sum[c] = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
        grid_weight[c] = (wt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wt[31:0];
        if (grid_count[c] != 16'hFFFF) grid_count[c] = grid_count[c] + 16'd1;
      end
    end
    res.splat_accepted = 1'b1;
    return res;
  endfunction

  initial begin
    for (int k = 0; k < Depth; k++) gauss_lut[k] = gauss_lut_entry(k);
  end

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    gsga_pkg::result_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      min_mz <= '0;
      step_mz <= 32'd65536;
      min_rt <= '0;
      step_rt <= 32'd65536;
      cols_reg <= 7'd64;
      rows_reg <= 7'd64;
      fail_cnt_o <= 0;
      expected_results.delete();
      for (int c = 0; c < NCols*NRows; c++) begin
        grid_sum[c] = '0;
        grid_weight[c] = '0;
        grid_count[c] = '0;
      end
    end else begin
      // compare before taking a new transfer
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (want.splat_accepted !== result_i.splat_accepted) begin
            $error("splat_accepted: expected %0h actual %0h",
                   want.splat_accepted, result_i.splat_accepted);
            errs++;
          end
          if (want.cell_sum_out !== result_i.cell_sum_out) begin
            $error("cell_sum_out: expected %0h actual %0h",
                   want.cell_sum_out, result_i.cell_sum_out);
            errs++;
          end
          if (want.cell_weight_out !== result_i.cell_weight_out) begin
            $error("cell_weight_out: expected %0h actual %0h",
                   want.cell_weight_out, result_i.cell_weight_out);
            errs++;
          end
          if (want.cell_count_out !== result_i.cell_count_out) begin
            $error("cell_count_out: expected %0h actual %0h",
                   want.cell_count_out, result_i.cell_count_out);
            errs++;
          end
        end
      end
      if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
      if (start_i && !busy_i) expected_results.push_back(predict_splat_or_read(item_i));
      if (cfg_we_i) begin
        case (gsga_pkg::cfg_idx_e'(cfg_idx_i))
          gsga_pkg::CFG_MIN_MZ:  min_mz <= cfg_wdata_i;
          gsga_pkg::CFG_STEP_MZ: step_mz <= cfg_wdata_i;
          gsga_pkg::CFG_MIN_RT:  min_rt <= cfg_wdata_i;
          gsga_pkg::CFG_STEP_RT: step_rt <= cfg_wdata_i;
          gsga_pkg::CFG_COLS:    cols_reg <= cfg_wdata_i[6:0];
          gsga_pkg::CFG_ROWS:    rows_reg <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/tb_top.sv
// Top of the splat grid accumulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int StallLimit = 1000000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  gsga_pkg::item_t               item_i;
  logic                          busy;
  logic                          done_o;
  gsga_pkg::result_t             result_o;
  logic                          cfg_we_i;
  logic [gsga_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [gsga_pkg::CfgDataW-1:0] cfg_wdata_i;
  int                            fail_cnt;
  int                            pending;
  int                            quiet_cycles;
  bit                            steady;

  logic [31:0] cur_min_mz, cur_step_mz, cur_min_rt, cur_step_rt;
  int          cur_cols, cur_rows;

  gaussian_splat_grid_accumulator_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item_i), .busy(busy),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  gsga_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .item_i(item_i),
    .done_i(done_o), .result_i(result_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // count cycles without any transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic send_item(input gsga_pkg::item_t it);
    if (!steady && $urandom_range(99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input gsga_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_grid(input logic [31:0] mmz, input logic [31:0] smz,
                           input logic [31:0] mrt, input logic [31:0] srt,
                           input logic [6:0] cols, input logic [6:0] rows);
    drain();
    write_cfg(gsga_pkg::CFG_MIN_MZ, mmz);
    write_cfg(gsga_pkg::CFG_STEP_MZ, smz);
    write_cfg(gsga_pkg::CFG_MIN_RT, mrt);
    write_cfg(gsga_pkg::CFG_STEP_RT, srt);
    write_cfg(gsga_pkg::CFG_COLS, 32'(cols));
    write_cfg(gsga_pkg::CFG_ROWS, 32'(rows));
    cur_min_mz = mmz;
    cur_step_mz = (smz == 0) ? 32'd1 : smz;
    cur_min_rt = mrt;
    cur_step_rt = (srt == 0) ? 32'd1 : srt;
    cur_cols = (cols == 0) ? 1 : ((cols > 64) ? 64 : int'(cols));
    cur_rows = (rows == 0) ? 1 : ((rows > 64) ? 64 : int'(rows));
  endtask

  // point near a cell of the grid and a sigma of one eighth to one and a half steps
  task automatic pick_axis(input logic [31:0] mn, input logic [31:0] st, input int n,
                           output logic [31:0] coord, output logic [31:0] sg);
    logic [63:0] c, s;
    int idx;
    idx = int'($urandom_range(n + 1)) - 1;
    c = 64'(mn) + 64'(signed'(64'(idx))) * 64'(st) + ((64'(st) * $urandom_range(255)) >> 8);
    s = (64'(st) * $urandom_range(1, 12)) >> 3;
    coord = c[31:0];
    sg = (s[31:0] == 0) ? 32'd1 : s[31:0];
  endtask

  function automatic gsga_pkg::item_t read_of(input int col, input int row);
    gsga_pkg::item_t it;
    it = '0;
    it.op = 1'b1;
    it.read_col = 6'(col);
    it.read_row = 6'(row);
    return it;
  endfunction

  function automatic gsga_pkg::item_t splat_of(input logic [31:0] mz, input logic [31:0] rt,
                                               input logic [31:0] amp, input logic [31:0] wmz,
                                               input logic [31:0] wrt);
    gsga_pkg::item_t it;
    it = '0;
    it.point_mz = mz;
    it.point_rt = rt;
    it.intensity = amp;
    it.width_mz = wmz;
    it.width_rt = wrt;
    return it;
  endfunction

  task automatic random_phase(input int count);
    gsga_pkg::item_t it;
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        it = read_of($urandom_range(cur_cols - 1), $urandom_range(cur_rows - 1));
        if ($urandom_range(9) == 0) it = read_of($urandom_range(63), $urandom_range(63));
        it.point_mz = $urandom();
        it.intensity = $urandom();
      end else if (roll < 90) begin
        it = '0;
        pick_axis(cur_min_mz, cur_step_mz, cur_cols, it.point_mz, it.width_mz);
        pick_axis(cur_min_rt, cur_step_rt, cur_rows, it.point_rt, it.width_rt);
        it.intensity = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom();
        it.read_col = 6'($urandom());
        it.read_row = 6'($urandom());
      end else if (roll < 95) begin
        it = splat_of($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        if ($urandom_range(1)) it.width_mz = '0;
        else it.width_rt = '0;
      end else begin
        it = '0;
        it.point_mz = $urandom();
        it.point_rt = $urandom();
        it.intensity = $urandom();
        it.width_mz = $urandom();
        it.width_rt = $urandom();
        it.read_col = 6'($urandom());
        it.read_row = 6'($urandom());
      end
      send_item(it);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = gsga_pkg::CFG_MIN_MZ;
    cfg_wdata_i = '0;
    quiet_cycles = 0;
    steady = 1'b0;
    cur_min_mz = 0;
    cur_step_mz = 32'd65536;
    cur_min_rt = 0;
    cur_step_rt = 32'd65536;
    cur_cols = 64;
    cur_rows = 64;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset grid, extremes of reads and of splat rejection
    send_item(read_of(0, 0));
    send_item(read_of(63, 63));
    send_item(splat_of(32'h0005_0000, 32'h0005_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                       32'h0001_0000));
    send_item(read_of(5, 5));
    send_item(read_of(4, 6));
    send_item(splat_of(32'h0005_0000, 32'h0005_0000, 32'd100, 32'd0, 32'h0001_0000));
    send_item(splat_of(32'h0005_0000, 32'h0005_0000, 32'd100, 32'h0001_0000, 32'd0));
    send_item(splat_of(32'h0001_0000, 32'h0005_0000, 32'd100, 32'h0001_0000,
                       32'h0001_0000));
    send_item(splat_of(32'h0005_0000, 32'h0000_8000, 32'd100, 32'h0001_0000,
                       32'h0001_0000));
    send_item(splat_of(32'h0064_0000, 32'h0005_0000, 32'd100, 32'h0001_0000,
                       32'h0001_0000));
    send_item(splat_of(32'h0005_0000, 32'h0050_0000, 32'd100, 32'h0001_0000,
                       32'h0001_0000));
    send_item(splat_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF));
    send_item(splat_of(32'h0003_2000, 32'h003E_8000, 32'd0, 32'h0000_8000,
                       32'h0000_4000));
    send_item(splat_of(32'h0020_0000, 32'h0020_0000, 32'h0012_3456, 32'h0008_0000,
                       32'h0008_0000));
    send_item(read_of(32, 32));
    send_item(read_of(63, 0));
    // hold off until the grid is quiet
    drain();
    send_item(read_of(5, 5));

    random_phase(150);
    load_grid(32'h000A_0000, 32'h0000_8000, 32'h0003_4000, 32'h0002_0000, 7'd8, 7'd5);
    random_phase(150);
    load_grid(32'hFFFF_FF00, 32'd0, 32'h8000_0000, 32'd0, 7'd0, 7'd127);
    random_phase(120);
    load_grid(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 7'd2, 7'd2);
    random_phase(120);
    load_grid(32'h1234_5678, 32'h0001_8000, 32'h0000_0100, 32'h0000_C000, 7'd64, 7'd33);
    steady = 1'b1;
    random_phase(150);
    steady = 1'b0;
    load_grid(32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000, 7'd64, 7'd64);
    random_phase(250);

    drain();
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### sim.f
design/gsga_pkg.sv
design/gaussian_splat_grid_accumulator_core.sv
tb/gsga_checker.sv
tb/tb_top.sv
